>>> design/amg_pkg.sv
// amg_pkg: shared types and constants for the adjacency matrix graph block
// depends on nothing
package amg_pkg;
  localparam int MAX_VERTICES = 32;
  localparam int LABEL_WIDTH = 32;
  localparam int VW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);

  typedef enum logic [2:0] {
    OP_ADD_VERTEX = 3'd0, OP_ADD_EDGE = 3'd1, OP_REMOVE_EDGE = 3'd2,
    OP_IS_EDGE = 3'd3, OP_READ_LABEL = 3'd4, OP_WRITE_LABEL = 3'd5,
    OP_NEIGHBORS = 3'd6, OP_DEPTH_FIRST = 3'd7
  } op_t;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [2:0]  op;
    logic [4:0]  source_vertex;
    logic [4:0]  target_vertex;
    logic [31:0] label;
  } in_item_t;

  typedef struct packed {
    logic [4:0]  vertex;
    logic [31:0] label_out;
    logic        edge_present;
    logic [31:0] neighbor_mask;
    logic [1:0]  status;
    logic        last;
  } out_item_t;

  // request from the sequencer to the memory unit
  typedef struct packed {
    logic                    row_re;
    logic [VW-1:0]           row_raddr;
    logic                    row_we;
    logic [VW-1:0]           row_waddr;
    logic [MAX_VERTICES-1:0] row_wdata;
    logic                    lab_re;
    logic [VW-1:0]           lab_raddr;
    logic                    lab_we;
    logic [VW-1:0]           lab_waddr;
    logic [LABEL_WIDTH-1:0]  lab_wdata;
  } mem_req_t;
endpackage

>>> design/adjacency_matrix_graph_dfs.sv
// adjacency_matrix_graph_dfs: top level of the graph block
// depends on amg_pkg, amg_mem and amg_ctrl
//
// Input channel in_valid/in_stall carries one operation per transaction; the
// output channel out_valid/out_stall carries result transactions, last set on
// the final result of each operation. One operation is taken at a time;
// in_stall is high from the cycle after acceptance until it is finished.
// Add vertex, edge, label and neighbor operations: the accept edge starts the
// registered row and label reads (or the new vertex writes), and the edge that
// leaves S_EXEC, once the output is free, does the write back and loads the
// result register.
// Depth first holds each visited vertex back until the next one is known, so
// that last can be set: it starts in S_EXEC, each further visited vertex takes a
// row read, a scan with label read and a result, a backtrack a row read and a scan.
// Reset empties the graph (vertex count zero); memory contents are not
// cleared, since no entry at or above the count is readable and each new
// vertex writes its own row and label. A new vertex needs no column clear:
// an edge can only point at a vertex that already exists.
// When the receiver stalls, the result holds and the operation or walk waits.
module adjacency_matrix_graph_dfs (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  amg_pkg::in_item_t   in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output amg_pkg::out_item_t  out_item
);
  import amg_pkg::*;

  mem_req_t req;
  logic [MAX_VERTICES-1:0] row_rdata;
  logic [LABEL_WIDTH-1:0] lab_rdata;

  amg_mem u_mem (.clk, .req, .row_rdata, .lab_rdata);

  amg_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .in_item, .out_valid, .out_stall,
    .out_item, .req, .row_rdata, .lab_rdata
  );
endmodule

>>> design/amg_mem.sv
// amg_mem: adjacency row memory and label memory, registered reads
// depends on amg_pkg
module amg_mem (
  input  logic                             clk,
  input  amg_pkg::mem_req_t                req,
  output logic [amg_pkg::MAX_VERTICES-1:0] row_rdata,
  output logic [amg_pkg::LABEL_WIDTH-1:0]  lab_rdata
);
  import amg_pkg::*;

  logic [MAX_VERTICES-1:0] rows [MAX_VERTICES];
  logic [LABEL_WIDTH-1:0]  labels [MAX_VERTICES];

  always_ff @(posedge clk) begin
    if (req.row_we) rows[req.row_waddr] <= req.row_wdata;
    if (req.row_re) row_rdata <= rows[req.row_raddr];
  end

  always_ff @(posedge clk) begin
    if (req.lab_we) labels[req.lab_waddr] <= req.lab_wdata;
    if (req.lab_re) lab_rdata <= labels[req.lab_raddr];
  end
endmodule

>>> design/amg_ctrl.sv
// amg_ctrl: operation sequencer, traversal stack and result register
// depends on amg_pkg; drives the amg_mem request
module amg_ctrl (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  amg_pkg::in_item_t                in_item,
  output logic                             out_valid,
  input  logic                             out_stall,
  output amg_pkg::out_item_t               out_item,
  output amg_pkg::mem_req_t                req,
  input  logic [amg_pkg::MAX_VERTICES-1:0] row_rdata,
  input  logic [amg_pkg::LABEL_WIDTH-1:0]  lab_rdata
);
  import amg_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_DFS_READ, S_DFS_SCAN, S_DFS_LAB, S_DFS_END
  } state_t;

  state_t state;
  in_item_t cur;
  logic [CW-1:0] vertex_count;
  logic [VW-1:0] add_idx;
  logic          add_full;
  logic [MAX_VERTICES-1:0] visited_mask;
  // walk stack: vertex and next scan position
  logic [VW-1:0] stk_v [MAX_VERTICES];
  logic [VW:0]   stk_p [MAX_VERTICES];
  logic [VW:0]   sp;
  logic [CW-1:0] nres;
  logic [VW-1:0] found;
  logic          found_ok;
  logic [VW-1:0] found_v;
  // visited vertex held back until it is known whether it is the last one
  logic [VW-1:0] pend_v;
  logic [LABEL_WIDTH-1:0] pend_lab;
  logic [VW-1:0] top_idx;
  logic [VW-1:0] top_v;
  logic [VW:0]   top_p;
  logic          push;
  logic          out_free;
  logic          emit;
  out_item_t     res, exec_res, pend_res, emit_res;
  logic [MAX_VERTICES-1:0] valid_mask, scan_row;

  logic s_ok, t_ok;
  assign s_ok = CW'(cur.source_vertex) < vertex_count;
  assign t_ok = CW'(cur.target_vertex) < vertex_count;

  always_comb begin
    for (int i = 0; i < MAX_VERTICES; i++)
      valid_mask[i] = (CW'(i) < vertex_count);
  end

  assign top_idx = sp[VW-1:0] - VW'(1);
  assign top_v = stk_v[top_idx];
  assign top_p = stk_p[top_idx];
  assign push = (sp != (VW+1)'(MAX_VERTICES));
  assign scan_row = row_rdata & valid_mask & ~visited_mask;

  // priority search for the first unvisited neighbor at or above the scan position
  always_comb begin
    found = '0;
    found_ok = 1'b0;
    for (int j = MAX_VERTICES - 1; j >= 0; j--)
      if (scan_row[j] && ((VW+1)'(j) >= top_p)) begin
        found = VW'(j);
        found_ok = 1'b1;
      end
  end

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign out_item = res;

  // result of a single-result operation, from the registered reads
  always_comb begin
    exec_res = '0;
    exec_res.last = 1'b1;
    exec_res.status = ST_RANGE;
    case (op_t'(cur.op)) inside
      OP_ADD_VERTEX: begin
        if (add_full) begin
          exec_res.status = ST_FULL;
        end else begin
          exec_res.status = ST_OK;
          exec_res.vertex = add_idx;
          exec_res.label_out = cur.label;
        end
      end
      OP_ADD_EDGE, OP_REMOVE_EDGE, OP_IS_EDGE: begin
        if (s_ok && t_ok) begin
          exec_res.status = ST_OK;
          exec_res.vertex = cur.source_vertex;
          exec_res.edge_present = (op_t'(cur.op) == OP_IS_EDGE) &&
                                  row_rdata[cur.target_vertex];
        end
      end
      default: begin
        if (s_ok) begin
          exec_res.status = ST_OK;
          exec_res.vertex = cur.source_vertex;
          case (op_t'(cur.op))
            OP_READ_LABEL: exec_res.label_out = 32'(lab_rdata);
            OP_WRITE_LABEL: exec_res.label_out = cur.label;
            OP_NEIGHBORS: exec_res.neighbor_mask = 32'(row_rdata & valid_mask);
            default: ;
          endcase
        end
      end
    endcase
  end

  always_comb begin
    pend_res = '0;
    pend_res.vertex = pend_v;
    pend_res.label_out = 32'(pend_lab);
    pend_res.status = ST_OK;
  end

  always_comb begin
    emit = 1'b0;
    emit_res = exec_res;
    unique case (state)
      S_EXEC: emit = out_free && !(op_t'(cur.op) == OP_DEPTH_FIRST && s_ok);
      S_DFS_LAB: begin
        emit = out_free;
        emit_res = pend_res;
        emit_res.last = 1'b0;
      end
      S_DFS_END: begin
        emit = out_free;
        emit_res = pend_res;
        emit_res.last = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    req = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (op_t'(in_item.op) == OP_ADD_VERTEX) begin
            if (vertex_count != CW'(MAX_VERTICES)) begin
              req.row_we = 1'b1;
              req.row_waddr = vertex_count[VW-1:0];
              req.row_wdata = '0;
              req.lab_we = 1'b1;
              req.lab_waddr = vertex_count[VW-1:0];
              req.lab_wdata = LABEL_WIDTH'(in_item.label);
            end
          end else begin
            req.row_re = 1'b1;
            req.row_raddr = in_item.source_vertex;
            req.lab_re = 1'b1;
            req.lab_raddr = in_item.source_vertex;
          end
        end
      end
      S_EXEC: begin
        // write back once, in the cycle the result is loaded
        if (emit && s_ok && t_ok &&
            (op_t'(cur.op) == OP_ADD_EDGE || op_t'(cur.op) == OP_REMOVE_EDGE)) begin
          req.row_we = 1'b1;
          req.row_waddr = cur.source_vertex;
          req.row_wdata = (op_t'(cur.op) == OP_ADD_EDGE) ?
            (row_rdata | (MAX_VERTICES'(1) << cur.target_vertex)) :
            (row_rdata & ~(MAX_VERTICES'(1) << cur.target_vertex));
        end
        if (emit && s_ok && op_t'(cur.op) == OP_WRITE_LABEL) begin
          req.lab_we = 1'b1;
          req.lab_waddr = cur.source_vertex;
          req.lab_wdata = LABEL_WIDTH'(cur.label);
        end
      end
      S_DFS_READ: begin
        if (nres != CW'(MAX_VERTICES)) begin
          req.row_re = 1'b1;
          req.row_raddr = top_v;
        end
      end
      S_DFS_SCAN: begin
        if (found_ok) begin
          req.lab_re = 1'b1;
          req.lab_raddr = found;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      vertex_count <= '0;
      visited_mask <= '0;
      out_valid <= 1'b0;
      sp <= '0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
        res <= emit_res;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cur <= in_item;
            add_idx <= vertex_count[VW-1:0];
            add_full <= (vertex_count == CW'(MAX_VERTICES));
            if (op_t'(in_item.op) == OP_ADD_VERTEX && vertex_count != CW'(MAX_VERTICES))
              vertex_count <= vertex_count + CW'(1);
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (op_t'(cur.op) == OP_DEPTH_FIRST && s_ok) begin
            visited_mask <= MAX_VERTICES'(1) << cur.source_vertex;
            stk_v[0] <= cur.source_vertex;
            stk_p[0] <= '0;
            sp <= (VW+1)'(1);
            nres <= CW'(1);
            pend_v <= cur.source_vertex;
            pend_lab <= lab_rdata;
            state <= S_DFS_READ;
          end else if (out_free) begin
            state <= S_IDLE;
          end
        end
        S_DFS_READ: begin
          if (nres == CW'(MAX_VERTICES)) state <= S_DFS_END;
          else state <= S_DFS_SCAN;
        end
        S_DFS_SCAN: begin
          if (found_ok) begin
            visited_mask <= visited_mask | (MAX_VERTICES'(1) << found);
            for (int i = 0; i < MAX_VERTICES; i++) begin
              if (VW'(i) == top_idx) stk_p[i] <= (VW+1)'(found) + (VW+1)'(1);
              else if (push && VW'(i) == sp[VW-1:0]) stk_p[i] <= '0;
            end
            if (push) begin
              stk_v[sp[VW-1:0]] <= found;
              sp <= sp + (VW+1)'(1);
            end
            nres <= nres + CW'(1);
            found_v <= found;
            state <= S_DFS_LAB;
          end else begin
            sp <= sp - (VW+1)'(1);
            if (sp == (VW+1)'(1)) state <= S_DFS_END;
            else state <= S_DFS_READ;
          end
        end
        S_DFS_LAB: begin
          // label of the new vertex is in lab_rdata; it becomes the held one
          if (out_free) begin
            pend_v <= found_v;
            pend_lab <= lab_rdata;
            state <= S_DFS_READ;
          end
        end
        S_DFS_END: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

>>> design/amg_checker.sv
// amg_checker: port-level checks on the graph block
// depends on amg_pkg; bound to adjacency_matrix_graph_dfs
module amg_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input amg_pkg::out_item_t out_item,
  input logic               out_valid,
  input logic               out_stall
);
  import amg_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("took a second operation at once");
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.status != ST_OK |-> out_item.last)
    else $error("error result without last");
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result after reset");
endmodule

bind adjacency_matrix_graph_dfs amg_checker u_chk (
  .clk, .rst, .in_valid, .in_stall, .out_item, .out_valid, .out_stall
);
